// ===== design/swcd_pkg.sv =====
package swcd_pkg;

   // CRC-8 used by the sensor: polynomial x^8+x^5+x^4+1, seed 0xFF, no final xor
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   // Position of a byte inside its three-byte group
   localparam logic [1:0] POS_MSB  = 2'd0;
   localparam logic [1:0] POS_LSB  = 2'd1;
   localparam logic [1:0] POS_CRC  = 2'd2;
   localparam logic [1:0] POS_RSVD = 2'd3;

   // One reply byte as it enters the block
   typedef struct packed {
      logic [7:0] reply_byte;
      logic       reply_start;
   } req_item_type;

   // One decoded word as it leaves the block
   typedef struct packed {
      logic [15:0] data_word;
      logic        word_ok;
      logic        reply_ok;
   } rsp_item_type;

   // Framing status reported by the word checker
   typedef struct packed {
      logic [1:0] position;
      logic       error_seen;
   } chk_status_type;

   // Feed one byte into the CRC, MSB first, eight shift steps unrolled
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== design/swcd_req_reg.sv =====
module swcd_req_reg
   import swcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         take,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // Hold the staged transaction while the next stage cannot take it
   assign req_stall = valid_ff && !take;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload only on an accepted transaction
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/swcd_word_check.sv =====
module swcd_word_check
   import swcd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  req_item_type   item,
   output logic           res_valid,
   output rsp_item_type   res_item,
   output chk_status_type status
);

   logic [1:0] pos_ff;
   logic [1:0] pos_in;
   logic [7:0] crc_ff;
   logic [7:0] crc_in;
   logic       err_ff;
   logic       err_in;
   logic [7:0] high_ff;
   logic [7:0] high_in;
   logic [7:0] low_ff;
   logic [7:0] low_in;

   logic [1:0] pos_base;
   logic [7:0] crc_base;
   logic       err_base;
   logic       crc_match;

   // A start marker restarts the group and the reply status
   assign pos_base  = item.reply_start ? POS_MSB  : pos_ff;
   assign crc_base  = item.reply_start ? CRC_INIT : crc_ff;
   assign err_base  = item.reply_start ? 1'b0     : err_ff;
   assign crc_match = (crc_base == item.reply_byte);

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      err_in    = err_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      res_valid = 1'b0;
      if (fire) begin
         err_in = err_base;
         unique case (pos_base)
            POS_LSB: begin
               low_in = item.reply_byte;
               crc_in = crc8_feed(crc_base, item.reply_byte);
               pos_in = POS_CRC;
            end
            POS_CRC: begin
               err_in    = err_base | !crc_match;
               crc_in    = CRC_INIT;
               pos_in    = POS_MSB;
               res_valid = 1'b1;
            end
            POS_MSB, POS_RSVD: begin
               high_in = item.reply_byte;
               crc_in  = crc8_feed(CRC_INIT, item.reply_byte);
               pos_in  = POS_LSB;
            end
            default: begin
               pos_in = POS_MSB;
            end
         endcase
      end
   end

   // Build the result from the stored bytes and this CRC byte
   assign res_item.data_word = {high_ff, low_ff};
   assign res_item.word_ok   = crc_match;
   assign res_item.reply_ok  = !(err_base | !crc_match);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_MSB;
         crc_ff <= CRC_INIT;
         err_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
      low_ff  <= low_in;
   end

   assign status.position   = pos_ff;
   assign status.error_seen = err_ff;

endmodule

// ===== design/swcd_rsp_reg.sv =====
module swcd_rsp_reg
   import swcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         res_valid,
   input  rsp_item_type res_item,
   output logic         free,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // Register can load when empty or when its transaction leaves this cycle
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && res_valid) begin
         item_ff <= res_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// ===== design/sensor_word_crc_deframer.sv =====
// Path: a result is valid on rsp_ once its CRC byte has passed the input
// register, then the result register; a stalled result holds both.
// Throughput: one reply byte per cycle while no stalled result holds the input;
// one result for every third byte. The CRC-8 step is unrolled between the two
// registers. Synchronous reset empties both registers, sets the group position
// to the MSB, the running CRC to 0xFF and clears the reply error flag.
module sensor_word_crc_deframer
   import swcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_reply_byte,
   input  logic        req_reply_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_data_word,
   output logic        rsp_word_ok,
   output logic        rsp_reply_ok
);

   req_item_type   req_item;
   req_item_type   stage_item;
   logic           stage_valid;
   logic           rsp_free;
   logic           stage_fire;
   logic           res_valid;
   rsp_item_type   res_item;
   rsp_item_type   rsp_item;
   chk_status_type chk_status;

   assign req_item.reply_byte  = req_reply_byte;
   assign req_item.reply_start = req_reply_start;

   // Advance the staged byte whenever the result register can load
   assign stage_fire = stage_valid && rsp_free;

   swcd_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (rsp_free),
      .item_valid (stage_valid),
      .item       (stage_item)
   );

   swcd_word_check u_word_check (
      .clock     (clock),
      .reset     (reset),
      .fire      (stage_fire),
      .item      (stage_item),
      .res_valid (res_valid),
      .res_item  (res_item),
      .status    (chk_status)
   );

   swcd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_item  (res_item),
      .free      (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_data_word = rsp_item.data_word;
   assign rsp_word_ok   = rsp_item.word_ok;
   assign rsp_reply_ok  = rsp_item.reply_ok;

   // A good reply status cannot accompany a failed word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_reply_ok || rsp_word_ok))
   else $error("reply_ok set on a word that failed its CRC");

   // A result is made only by a byte that advances out of the input register
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> stage_fire)
   else $error("result produced without an advancing byte");

   // The group position never takes the reserved code
   assert property (@(posedge clock) disable iff (reset)
      chk_status.position != POS_RSVD)
   else $error("group position left the three-byte cycle");

   // After a failed word the reply error flag is set
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_item.word_ok) |=> chk_status.error_seen)
   else $error("reply error flag not set after a CRC failure");

endmodule
